// ===== rtl/fat12_cluster_chain_walker_core_defines.svh =====
// ----------------------------------------------------------------------------
// FAT12 chain walker assertion macros
// Concurrent assertion shorthands on clk_i with rst_ni as disable.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_CORE_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_CORE_DEFINES_SVH

// same-cycle implication
`define FCCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fat12ccw_pkg.sv =====
// ----------------------------------------------------------------------------
// fat12ccw_pkg
// Shared types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fat12ccw_pkg;

  localparam int TABLE_BYTES = 8192;
  localparam int MAX_CHAIN   = 64;
  localparam int TABLE_AW    = $clog2(TABLE_BYTES);
  localparam int POS_W       = 14;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SECTORS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_START_LBA  = 8'd1;

  localparam logic [7:0]  SPC_RESET        = 8'd1;
  localparam logic [15:0] DATA_START_RESET = 16'd33;

  localparam logic [11:0] CLUSTER_FIRST = 12'h002;
  localparam logic [11:0] CLUSTER_LAST  = 12'hFEF;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_WALK  = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [12:0] table_byte_index;
    logic [7:0]  table_byte_value;
    logic [11:0] start_cluster;
  } in_item_t;

  typedef struct packed {
    logic [11:0] cluster_number;
    logic [23:0] sector_lba;
    logic [5:0]  chain_position;
    logic        last;
  } out_item_t;

  function automatic logic in_range(logic [11:0] c);
    return (c >= CLUSTER_FIRST) && (c <= CLUSTER_LAST);
  endfunction

endpackage

// ===== rtl/fat12ccw_if.sv =====
// ----------------------------------------------------------------------------
// fat12ccw interfaces
// Valid/ready channels for input items, result items and config writes.
// ----------------------------------------------------------------------------
interface fat12ccw_in_if;
  import fat12ccw_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface fat12ccw_out_if;
  import fat12ccw_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface fat12ccw_cfg_if;
  import fat12ccw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fat12ccw_ram.sv =====
// ----------------------------------------------------------------------------
// fat12ccw_ram
// Single-port synchronous RAM, registered read data held between reads.
// ----------------------------------------------------------------------------
module fat12ccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fat12_cluster_chain_walker_core.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_core
// Follows a FAT12 cluster chain through a byte-wide table RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : input items. opcode write stores one table byte (no result);
//           opcode walk follows the chain from start_cluster. An invalid
//           start is taken and gives no result.
//   out_o : one result item per cluster; last flags the end of the chain.
//   cfg_i : register writes, always ready; issue them only while idle.
// Sequence: each cluster passes through S_RD0, S_RD1 and S_EMIT (two byte
//   reads on the single table RAM port, then the entry decode), and S_EMIT
//   stalls while the output register is full and not taken; a walk covers
//   at most 64 clusters. in_i is ready only between walks.
// Reset: registers return to sectors per cluster 1, data start 33; the table
//   RAM is not cleared, unwritten bytes read as anything.
// Stall: results sit in an output register; while it is full the walker
//   holds its decoded entry, and after the last result it takes new items.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  fat12ccw_in_if.sink       in_i,
  fat12ccw_out_if.source    out_o,
  fat12ccw_cfg_if.sink      cfg_i
);
  import fat12ccw_pkg::*;

  `include "fat12_cluster_chain_walker_core_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD0  = 4'b0010,
    S_RD1  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [11:0] cur_q, cur_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [7:0]  lo_q, lo_d;
  logic [19:0] prod_q, prod_d;
  logic [7:0]  spc_q;
  logic [15:0] ds_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q, out_item_d;

  logic                in_acc, idx_ok;
  logic [POS_W-1:0]    pos, pos1;
  logic                entry_oob;
  logic [15:0]         word;
  logic [11:0]         nxt;
  logic                done, out_load;
  logic                ram_en, ram_we;
  logic [TABLE_AW-1:0] ram_addr;
  logic [7:0]          ram_rdata;

  // config port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q <= SPC_RESET;
      ds_q  <= DATA_START_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_CLUSTER_SECTORS) begin
        spc_q <= cfg_i.data[7:0];
      end else if (cfg_i.index == REG_DATA_START_LBA) begin
        ds_q <= cfg_i.data;
      end
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign idx_ok     = {1'b0, in_i.item.table_byte_index} < POS_W'(TABLE_BYTES);

  // entry at byte cluster + cluster/2
  assign pos       = {2'b00, cur_q} + {3'b000, cur_q[11:1]};
  assign pos1      = pos + POS_W'(1);
  assign entry_oob = pos1 >= POS_W'(TABLE_BYTES);

  assign word = {ram_rdata, lo_q};
  always_comb begin
    if (entry_oob) begin
      nxt = 12'h000;
    end else if (cur_q[0]) begin
      nxt = word[15:4];
    end else begin
      nxt = word[11:0];
    end
  end

  assign done     = (cnt_q == 6'(MAX_CHAIN - 1)) || !in_range(nxt);
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // RAM port
  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = pos[TABLE_AW-1:0];
    case (state_q)
      S_IDLE: begin
        ram_we   = 1'b1;
        ram_en   = in_acc && (in_i.item.opcode == OP_WRITE) && idx_ok;
        ram_addr = in_i.item.table_byte_index[TABLE_AW-1:0];
      end
      S_RD0: begin
        ram_en = 1'b1;
      end
      S_RD1: begin
        ram_en   = 1'b1;
        ram_addr = pos1[TABLE_AW-1:0];
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  fat12ccw_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_i.item.table_byte_value),
    .rdata_o (ram_rdata)
  );

  // walk sequencer
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    lo_d    = lo_q;
    prod_d  = prod_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.item.opcode == OP_WALK)
            && in_range(in_i.item.start_cluster)) begin
          cur_d   = in_i.item.start_cluster;
          cnt_d   = 6'd0;
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        prod_d  = (cur_q - CLUSTER_FIRST) * spc_q;
        state_d = S_RD1;
      end
      S_RD1: begin
        lo_d    = ram_rdata;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          if (done) begin
            state_d = S_IDLE;
          end else begin
            cur_d   = nxt;
            cnt_d   = cnt_q + 6'd1;
            state_d = S_RD0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= 12'h000;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    prod_q <= prod_d;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_item_d  = out_item_q;
    if (out_load) begin
      out_valid_d               = 1'b1;
      out_item_d.cluster_number = cur_q;
      out_item_d.sector_lba     = 24'(ds_q) + 24'(prod_q);
      out_item_d.chain_position = cnt_q;
      out_item_d.last           = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  `FCCW_ASSERT_NXT(a_last_ends_walk, out_load && done, state_q == S_IDLE,
                   "walk did not end after last result")
  `FCCW_ASSERT_IMP(a_cluster_range, out_valid_q,
                   in_range(out_item_q.cluster_number),
                   "result cluster out of range")
  `FCCW_ASSERT_IMP(a_no_write_in_walk, ram_en && ram_we, state_q == S_IDLE,
                   "table write during a walk")
  `FCCW_ASSERT_NXT(a_walk_start, state_q == S_IDLE && state_d == S_RD0,
                   cnt_q == 6'd0,
                   "walk started with nonzero chain position")

endmodule
